// ----- rtl/hshade_pkg.sv -----
// Shared constants, register codes and configuration types of the hillshade stencil core.
`default_nettype none

package hshade_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_COLS_DEF  = 1024;
  localparam int unsigned ELEV_BITS_DEF = 24;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register and field widths.
  localparam int unsigned COLS_REG_W = 11;
  localparam int unsigned ROWS_W     = 16;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned TRIG_W     = 16;
  localparam int unsigned OUT_COL_W  = 10;
  localparam int unsigned SHADE_W    = 16;
  localparam int unsigned ROW_CNT_W  = ROWS_W + 1;
  localparam int unsigned OUT_TDATA_W = 48;

  // Normalization bound: every part of the vector ends up below 2^NORM_W.
  localparam int unsigned NORM_W = 28;
  localparam int unsigned V0_W   = 21;

  localparam logic [SHADE_W-1:0] SHADE_MAX = 16'hFF00;

  // Depth of the job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLS    = 3'd0,
    REG_ROWS    = 3'd1,
    REG_GAIN    = 3'd2,
    REG_COS_ZEN = 3'd3,
    REG_SIN_ZEN = 3'd4,
    REG_COS_DIR = 3'd5,
    REG_SIN_DIR = 3'd6
  } hs_reg_e;

  // Frame geometry as seen by the front.
  typedef struct packed {
    logic [COLS_REG_W-1:0] cols;
    logic [ROWS_W-1:0]     rows;
  } hs_geom_t;

  // Gain and light vector as seen by the back.
  typedef struct packed {
    logic        [GAIN_W-1:0] gain;
    logic signed [TRIG_W-1:0] cos_zen;
    logic signed [TRIG_W-1:0] sin_zen;
    logic signed [TRIG_W-1:0] cos_dir;
    logic signed [TRIG_W-1:0] sin_dir;
  } hs_light_t;

endpackage

`default_nettype wire

// ----- rtl/hshade_queue.sv -----
// Short first-in first-out queue of jobs between the front and the back.
`default_nettype none

module hshade_queue
  import hshade_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic      [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Payload slots.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hshade_front.sv -----
// Stencil front: line stores, 3x3 window, Horn gradients and cell position.
`default_nettype none

module hshade_front
  import hshade_pkg::*;
#(
  parameter int unsigned MAX_COLS  = MAX_COLS_DEF,
  parameter int unsigned ELEV_BITS = ELEV_BITS_DEF,
  parameter int unsigned JOB_W     = 2 * (ELEV_BITS + 4) + OUT_COL_W + ROWS_W + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 restart_i,
  input  wire hs_geom_t             geom_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [ELEV_BITS-1:0] elev_i,
  input  wire logic                 sample_ok_i,
  output logic                      job_valid_o,
  input  wire logic                 job_ready_i,
  output logic      [JOB_W-1:0]     job_o
);

  localparam int unsigned CW     = $clog2(MAX_COLS);
  localparam int unsigned WW     = $clog2(MAX_COLS + 1);
  localparam int unsigned CELL_W = ELEV_BITS + 1;
  localparam int unsigned GW     = ELEV_BITS + 4;
  localparam int unsigned RS_W   = ROW_CNT_W + 1;
  localparam logic signed [RS_W-1:0] RS_ONE = RS_W'(1);
  localparam logic signed [RS_W-1:0] RS_TWO = RS_W'(2);

  typedef struct packed {
    logic                        ok;
    logic signed [ELEV_BITS-1:0] v;
  } cell_t;

  typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_WORK} state_e;

  state_e                state_q;
  logic [CW-1:0]         clr_q, ic_q;
  logic [ROW_CNT_W-1:0]  ir_q;
  cell_t                 win_q [3][3];
  cell_t                 in_q;
  logic [2*CELL_W-1:0]   mem_q [MAX_COLS];
  logic [2*CELL_W-1:0]   rd_q;

  logic [WW-1:0]         w_eff, ic_inc;
  logic [ROWS_W-1:0]     r_eff;
  logic [CW-1:0]         cc;
  logic signed [RS_W-1:0] crs, r_ext;
  logic                  has_res, is_last, wrap, advance, in_fire;
  logic                  top, bot, lft, rgt;
  cell_t                 nw [3];
  cell_t                 cur [3][3];
  logic signed [ELEV_BITS-1:0] e, a, b, c, d, f, g, h, k;
  logic signed [GW-1:0]  gx, gy;
  logic                  mem_we;
  logic [CW-1:0]         mem_addr;
  logic [2*CELL_W-1:0]   mem_wdata;

  function automatic logic signed [ELEV_BITS-1:0] pick(
    input logic use_n, input cell_t nb, input logic signed [ELEV_BITS-1:0] ctr);
    return (use_n && nb.ok) ? nb.v : ctr;
  endfunction

  function automatic logic signed [GW-1:0] sx(input logic signed [ELEV_BITS-1:0] x);
    return GW'(x);
  endfunction

  // Effective geometry: zero acts as one, columns capped at the store depth.
  always_comb begin
    if (geom_i.cols == '0) begin
      w_eff = WW'(1);
    end else if (32'(geom_i.cols) > 32'(MAX_COLS)) begin
      w_eff = WW'(MAX_COLS);
    end else begin
      w_eff = WW'(geom_i.cols);
    end
    r_eff = (geom_i.rows == '0) ? ROWS_W'(1) : geom_i.rows;
  end

  // Position of the centre cell, one row plus one cell behind the input.
  always_comb begin
    ic_inc  = WW'(ic_q) + 1'b1;
    wrap    = (ic_inc >= w_eff);
    cc      = (ic_q != '0) ? ic_q - 1'b1 : CW'(w_eff - 1'b1);
    crs     = $signed({1'b0, ir_q}) - ((ic_q != '0) ? RS_ONE : RS_TWO);
    r_ext   = $signed(RS_W'(r_eff));
    has_res = !crs[RS_W-1] && (crs < r_ext);
    top     = (crs > RS_W'(0));
    bot     = (crs < r_ext - RS_ONE);
    lft     = (cc != '0);
    rgt     = (WW'(cc) < w_eff - 1'b1);
    is_last = (crs == r_ext - RS_ONE) && (WW'(cc) == w_eff - 1'b1);
  end

  // Window as it stands with the new column shifted in.
  always_comb begin
    nw[0] = cell_t'(rd_q[CELL_W-1:0]);
    nw[1] = cell_t'(rd_q[2*CELL_W-1:CELL_W]);
    nw[2] = in_q;
    for (int i = 0; i < 3; i++) begin
      cur[i][0] = win_q[i][1];
      cur[i][1] = win_q[i][2];
      cur[i][2] = nw[i];
    end
  end

  // Missing neighbours take the centre value; Horn gradients.
  always_comb begin
    e  = cur[1][1].ok ? cur[1][1].v : '0;
    a  = pick(top && lft, cur[0][0], e);
    b  = pick(top,        cur[0][1], e);
    c  = pick(top && rgt, cur[0][2], e);
    d  = pick(lft,        cur[1][0], e);
    f  = pick(rgt,        cur[1][2], e);
    g  = pick(bot && lft, cur[2][0], e);
    h  = pick(bot,        cur[2][1], e);
    k  = pick(bot && rgt, cur[2][2], e);
    gx = (sx(c) + sx(f) + sx(f) + sx(k)) - (sx(a) + sx(d) + sx(d) + sx(g));
    gy = (sx(g) + sx(h) + sx(h) + sx(k)) - (sx(a) + sx(b) + sx(b) + sx(c));
  end

  assign in_ready_o  = (state_q == ST_RUN);
  assign in_fire     = in_valid_i && in_ready_o;
  assign job_valid_o = (state_q == ST_WORK) && has_res;
  assign advance     = (state_q == ST_WORK) && (!has_res || job_ready_i);
  assign job_o       = {is_last, ROWS_W'(crs), OUT_COL_W'(cc), gy, gx};

  // One write port shared by the clearing sweep and the row update.
  always_comb begin
    mem_we    = (state_q == ST_CLEAR) || advance;
    mem_addr  = (state_q == ST_CLEAR) ? clr_q : ic_q;
    mem_wdata = (state_q == ST_CLEAR) ? '0 : {nw[2], nw[1]};
  end

  // Line store memory: upper row in the low half, middle row in the high half.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_q <= mem_q[ic_q];
    end
  end

  // Sequencer, counters and window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ic_q    <= '0;
      ir_q    <= '0;
      in_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (restart_i) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      ic_q    <= '0;
      ir_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j].ok <= 1'b0;
        end
      end
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CW'(MAX_COLS - 1)) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (in_fire) begin
            in_q    <= '{ok: sample_ok_i, v: elev_i};
            state_q <= ST_WORK;
          end
        end
        ST_WORK: begin
          if (advance) begin
            for (int i = 0; i < 3; i++) begin
              for (int j = 0; j < 3; j++) begin
                win_q[i][j] <= cur[i][j];
              end
            end
            if (has_res && is_last) begin
              ic_q <= '0;
              ir_q <= '0;
            end else if (wrap) begin
              ic_q <= '0;
              ir_q <= ir_q + 1'b1;
            end else begin
              ic_q <= CW'(ic_inc);
            end
            state_q <= ST_RUN;
          end
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hshade_back.sv -----
// Shading back end: gain, normalization, light dot product, square root and division.
`default_nettype none

module hshade_back
  import hshade_pkg::*;
#(
  parameter int unsigned ELEV_BITS = ELEV_BITS_DEF,
  parameter int unsigned JOB_W     = 2 * (ELEV_BITS + 4) + OUT_COL_W + ROWS_W + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hs_light_t          light_i,
  input  wire logic               job_valid_i,
  output logic                    job_ready_o,
  input  wire logic [JOB_W-1:0]   job_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [SHADE_W-1:0] out_shade_o,
  output logic      [OUT_COL_W-1:0] out_col_o,
  output logic      [ROWS_W-1:0]  out_row_o,
  output logic                    out_last_o
);

  localparam int unsigned GW     = ELEV_BITS + 4;
  localparam int unsigned PW     = GW + GAIN_W - 1;
  localparam int unsigned PRD_W  = GW + GAIN_W + 1;
  localparam int unsigned PQ_W   = NORM_W + 1;
  localparam int unsigned T_W    = PQ_W + TRIG_W + 1;
  localparam int unsigned D_W    = 64;
  localparam int unsigned SQ_W   = 2 * NORM_W + 2;
  localparam int unsigned ROOT_W = SQ_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 1;
  localparam int unsigned RT_W   = ROOT_W + 3;
  localparam int unsigned QT_W   = D_W - 1;
  localparam int unsigned CNT_W  = 6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MULP, ST_MULQ, ST_NORM, ST_T1, ST_T2, ST_T3, ST_T4,
    ST_SQ1, ST_SQ2, ST_SQ3, ST_SQRT, ST_DIV, ST_FIN
  } state_e;

  state_e                 state_q;
  logic signed [GW-1:0]   gx_q, gy_q;
  logic [OUT_COL_W-1:0]   col_q;
  logic [ROWS_W-1:0]      row_q;
  logic                   last_q;
  logic [PW-1:0]          pm_q, qm_q, m_q;
  logic                   pneg_q, qneg_q, zero_q;
  logic [V0_W-1:0]        v0_q;
  logic signed [T_W-1:0]  t_q;
  logic signed [D_W-1:0]  d_q;
  logic [SQ_W-1:0]        n2_q;
  logic [REM_W-1:0]       rem_q;
  logic [ROOT_W-1:0]      root_q, drem_q;
  logic [CNT_W-1:0]       cnt_q;

  logic                   out_valid_q, out_last_q;
  logic [SHADE_W-1:0]     out_shade_q;
  logic [OUT_COL_W-1:0]   out_col_q;
  logic [ROWS_W-1:0]      out_row_q;

  logic signed [PRD_W-1:0] prod;
  logic [PW-1:0]          prod_mag;
  logic signed [PQ_W-1:0] ps, qs;
  logic [RT_W-1:0]        rt, trial;
  logic [ROOT_W:0]        dt;
  logic [D_W-1:0]         scaled;
  logic [D_W-31:0]        sh;
  logic [SHADE_W-1:0]     shade_calc;
  logic                   out_load;

  // Gain multiplier, shared by both gradients.
  always_comb begin
    prod     = $signed((state_q == ST_MULP) ? gx_q : gy_q)
             * $signed({1'b0, light_i.gain});
    prod_mag = PW'(prod[PRD_W-1] ? -prod : prod);
  end

  // Signed gradient parts after normalization.
  always_comb begin
    ps = pneg_q ? -$signed({1'b0, pm_q[NORM_W-1:0]}) : $signed({1'b0, pm_q[NORM_W-1:0]});
    qs = qneg_q ? -$signed({1'b0, qm_q[NORM_W-1:0]}) : $signed({1'b0, qm_q[NORM_W-1:0]});
  end

  // One digit of the square root and one bit of the quotient per cycle.
  always_comb begin
    rt    = {rem_q, n2_q[SQ_W-1:SQ_W-2]};
    trial = RT_W'({root_q, 2'b01});
    dt    = {drem_q, d_q[QT_W-1]};
  end

  // Quotient times 65280, scaled down by 2^30 and saturated.
  always_comb begin
    scaled = (D_W'(d_q[QT_W-1:0]) << 16) - (D_W'(d_q[QT_W-1:0]) << 8);
    sh     = scaled[D_W-1:30];
    if (zero_q) begin
      shade_calc = '0;
    end else if (sh > (D_W-30)'(SHADE_MAX)) begin
      shade_calc = SHADE_MAX;
    end else begin
      shade_calc = SHADE_W'(sh);
    end
  end

  assign job_ready_o = (state_q == ST_IDLE);
  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_shade_o = out_shade_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign out_last_o  = out_last_q;

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_shade_q <= shade_calc;
        out_col_q   <= col_q;
        out_row_q   <= row_q;
        out_last_q  <= last_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            {last_q, row_q, col_q, gy_q, gx_q} <= job_i;
            state_q <= ST_MULP;
          end
        end
        ST_MULP: begin
          pm_q    <= prod_mag;
          pneg_q  <= prod[PRD_W-1];
          v0_q    <= V0_W'(1) << 20;
          state_q <= ST_MULQ;
        end
        ST_MULQ: begin
          qm_q   <= prod_mag;
          qneg_q <= prod[PRD_W-1];
          if (pm_q >= prod_mag && pm_q > PW'(1 << 20)) begin
            m_q <= pm_q;
          end else if (prod_mag > PW'(1 << 20)) begin
            m_q <= prod_mag;
          end else begin
            m_q <= PW'(1 << 20);
          end
          state_q <= ST_NORM;
        end
        ST_NORM: begin
          if (|m_q[PW-1:NORM_W]) begin
            m_q  <= m_q >> 1;
            pm_q <= pm_q >> 1;
            qm_q <= qm_q >> 1;
            v0_q <= v0_q >> 1;
          end else begin
            state_q <= ST_T1;
          end
        end
        ST_T1: begin
          t_q     <= T_W'(qs * light_i.sin_dir);
          state_q <= ST_T2;
        end
        ST_T2: begin
          t_q     <= t_q - T_W'(ps * light_i.cos_dir);
          state_q <= ST_T3;
        end
        ST_T3: begin
          d_q     <= D_W'(light_i.sin_zen * t_q);
          state_q <= ST_T4;
        end
        ST_T4: begin
          d_q     <= d_q + (D_W'(light_i.cos_zen * $signed({1'b0, v0_q})) <<< 15);
          state_q <= ST_SQ1;
        end
        ST_SQ1: begin
          n2_q    <= SQ_W'(pm_q[NORM_W-1:0] * pm_q[NORM_W-1:0]);
          state_q <= ST_SQ2;
        end
        ST_SQ2: begin
          n2_q    <= n2_q + SQ_W'(qm_q[NORM_W-1:0] * qm_q[NORM_W-1:0]);
          state_q <= ST_SQ3;
        end
        ST_SQ3: begin
          n2_q   <= n2_q + SQ_W'(v0_q * v0_q);
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= CNT_W'(ROOT_W - 1);
          if (d_q <= 0) begin
            zero_q  <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            zero_q  <= 1'b0;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (rt >= trial) begin
            rem_q  <= REM_W'(rt - trial);
            root_q <= {root_q[ROOT_W-2:0], 1'b1};
          end else begin
            rem_q  <= REM_W'(rt);
            root_q <= {root_q[ROOT_W-2:0], 1'b0};
          end
          n2_q  <= n2_q << 2;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            drem_q  <= '0;
            cnt_q   <= CNT_W'(QT_W - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (root_q == '0) begin
            zero_q  <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            if (dt >= {1'b0, root_q}) begin
              drem_q <= ROOT_W'(dt - {1'b0, root_q});
              d_q    <= {1'b0, d_q[QT_W-2:0], 1'b1};
            end else begin
              drem_q <= ROOT_W'(dt);
              d_q    <= {1'b0, d_q[QT_W-2:0], 1'b0};
            end
            cnt_q <= cnt_q - 1'b1;
            if (cnt_q == '0) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hillshade_3x3_stencil_core.sv -----
// Top level of the Horn 3x3 hillshade core: configuration registers, front, queue and back.
`default_nettype none

// Elevation samples enter in raster order, one beat per sample with its valid flag on
// tuser; the shade of each centre cell leaves one row plus one cell later, so a frame is
// flushed with cols_in_use+1 filler beats. The front alternates between taking a sample
// (registered line store read) and the window update, which waits while the queue is
// full. The back is a single iterative unit that takes one cell at a time (gradient
// scaling loop, bit-serial square root, bit-serial division); cells whose light term is
// not positive skip the square root and division. The back sets the sustained rate.
// After reset and after each write of cols_in_use or rows_in_use the line stores are
// cleared, and no sample is accepted until the clearing sweep ends.
module hillshade_3x3_stencil_core
  import hshade_pkg::*;
#(
  parameter int unsigned MAX_COLS  = MAX_COLS_DEF,
  parameter int unsigned ELEV_BITS = ELEV_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]              cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]             cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // elevation
  input  wire logic [((ELEV_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // sample_valid
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // shade, out_col, out_row
  output logic      [OUT_TDATA_W-1:0]            m_axis_tdata,
  output logic                                   m_axis_tlast
);

  localparam int unsigned GW    = ELEV_BITS + 4;
  localparam int unsigned JOB_W = 2 * GW + OUT_COL_W + ROWS_W + 1;
  localparam int unsigned PAD_W = OUT_TDATA_W - SHADE_W - OUT_COL_W - ROWS_W;

  hs_geom_t           geom_q;
  hs_light_t          light_q;
  logic               restart;
  logic               fj_valid, fj_ready, bj_valid, bj_ready;
  logic [JOB_W-1:0]   fj_data, bj_data;
  logic [SHADE_W-1:0] shade;
  logic [OUT_COL_W-1:0] out_col;
  logic [ROWS_W-1:0]  out_row;

  // Geometry writes restart the frame.
  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      unique case (hs_reg_e'(cfg_idx_i))
        REG_COLS, REG_ROWS: restart = 1'b1;
        default:            restart = 1'b0;
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.cols     <= COLS_REG_W'(1024);
      geom_q.rows     <= ROWS_W'(1);
      light_q.gain    <= GAIN_W'(65536);
      light_q.cos_zen <= TRIG_W'(23170);
      light_q.sin_zen <= TRIG_W'(23170);
      light_q.cos_dir <= -TRIG_W'(23170);
      light_q.sin_dir <= TRIG_W'(23170);
    end else if (cfg_we_i) begin
      unique case (hs_reg_e'(cfg_idx_i))
        REG_COLS:    geom_q.cols     <= cfg_data_i[COLS_REG_W-1:0];
        REG_ROWS:    geom_q.rows     <= cfg_data_i[ROWS_W-1:0];
        REG_GAIN:    light_q.gain    <= cfg_data_i[GAIN_W-1:0];
        REG_COS_ZEN: light_q.cos_zen <= cfg_data_i[TRIG_W-1:0];
        REG_SIN_ZEN: light_q.sin_zen <= cfg_data_i[TRIG_W-1:0];
        REG_COS_DIR: light_q.cos_dir <= cfg_data_i[TRIG_W-1:0];
        REG_SIN_DIR: light_q.sin_dir <= cfg_data_i[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  hshade_front #(
    .MAX_COLS  (MAX_COLS),
    .ELEV_BITS (ELEV_BITS),
    .JOB_W     (JOB_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .geom_i      (geom_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .elev_i      (s_axis_tdata[ELEV_BITS-1:0]),
    .sample_ok_i (s_axis_tuser),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj_data)
  );

  hshade_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  (fj_data),
    .pop_valid_o  (bj_valid),
    .pop_ready_i  (bj_ready),
    .pop_data_o   (bj_data)
  );

  hshade_back #(
    .ELEV_BITS (ELEV_BITS),
    .JOB_W     (JOB_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .light_i     (light_q),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_i       (bj_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_shade_o (shade),
    .out_col_o   (out_col),
    .out_row_o   (out_row),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {PAD_W'(0), out_row, out_col, shade};

endmodule

`default_nettype wire

// ----- tb/hshade_checker.sv -----
// Checker for the hillshade stencil core: tracks configuration, predicts each shade beat and compares.
`timescale 1ns / 1ps

module hshade_checker
  import hshade_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [23:0]           s_axis_tdata,
  input  wire logic                  s_axis_tuser,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                  m_axis_tlast,
  output int                         err_count_o,
  output int                         pending_o
);

  localparam int NCOLS = 1024;

  typedef struct {
    logic [SHADE_W-1:0]   shade;
    logic [OUT_COL_W-1:0] col;
    logic [ROWS_W-1:0]    row;
    logic                 last;
  } shade_beat_t;

  shade_beat_t shade_expect_q[$];

  // Shadow copy of the register file.
  logic [COLS_REG_W-1:0] cols_reg;
  logic [ROWS_W-1:0]     rows_reg;
  longint                gain_reg, cos_zen, sin_zen, cos_dir, sin_dir;

  // Shadow copy of the line stores, the window and the raster position.
  longint upper_v[NCOLS];
  bit     upper_ok[NCOLS];
  longint middle_v[NCOLS];
  bit     middle_ok[NCOLS];
  longint win_v[3][3];
  bit     win_ok[3][3];
  int     col_cnt, row_cnt;

  function automatic longint unsigned magnitude(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint shift_toward_zero(longint x, int s);
    longint unsigned m;
    m = magnitude(x) >> s;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Lambertian shade of a cell from its Horn gradients, in Q8.8.
  function automatic logic [SHADE_W-1:0] horn_shade(longint gx, longint gy);
    longint          big_p, big_q, v0, p, q, lit;
    longint unsigned m, n, r, sh;
    int              s;
    big_p = gx * gain_reg;
    big_q = gy * gain_reg;
    m = 64'd1 << 20;
    if (magnitude(big_p) > m) m = magnitude(big_p);
    if (magnitude(big_q) > m) m = magnitude(big_q);
    s = 0;
    while ((m >> s) >= (64'd1 << NORM_W)) s++;
    v0 = longint'((64'd1 << 20) >> s);
    p = shift_toward_zero(big_p, s);
    q = shift_toward_zero(big_q, s);
    lit = cos_zen * v0 * 32768 + sin_zen * (q * sin_dir - p * cos_dir);
    if (lit <= 0) return '0;
    n = int_sqrt(longint'(v0 * v0 + p * p + q * q));
    if (n == 0) return '0;
    r = longint'(lit) / n;
    sh = (r * 65280) >> 30;
    return (sh > 65280) ? SHADE_MAX : sh[SHADE_W-1:0];
  endfunction

  task automatic restart_frame();
    for (int i = 0; i < NCOLS; i++) begin
      upper_v[i] = 0; upper_ok[i] = 0;
      middle_v[i] = 0; middle_ok[i] = 0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        win_v[i][j] = 0; win_ok[i][j] = 0;
      end
    col_cnt = 0;
    row_cnt = 0;
  endtask

  // Advance the raster by one sample and queue the shade it completes, if any.
  task automatic take_sample(longint elev, bit ok);
    int          w, h, ic, ir, cc, cr;
    longint      nv[3], e, a, b, c, d, f, g, hh, k;
    bit          nok[3], top, bot, lft, rgt, got;
    longint      wv[3][3];
    bit          wok[3][3];
    shade_beat_t beat;
    w = (cols_reg == 0) ? 1 : ((cols_reg > NCOLS) ? NCOLS : int'(cols_reg));
    h = (rows_reg == 0) ? 1 : int'(rows_reg);
    ic = col_cnt % w;
    ir = row_cnt;
    nv[0] = upper_v[ic];  nok[0] = upper_ok[ic];
    nv[1] = middle_v[ic]; nok[1] = middle_ok[ic];
    nv[2] = elev;         nok[2] = ok;
    if (ic > 0) begin
      cc = ic - 1; cr = ir - 1;
    end else begin
      cc = w - 1; cr = ir - 2;
    end
    got = 0;
    if (cr >= 0 && cr < h) begin
      for (int i = 0; i < 3; i++) begin
        wv[i][0] = win_v[i][1]; wok[i][0] = win_ok[i][1];
        wv[i][1] = win_v[i][2]; wok[i][1] = win_ok[i][2];
        wv[i][2] = nv[i];       wok[i][2] = nok[i];
      end
      top = cr > 0; bot = cr < h - 1; lft = cc > 0; rgt = cc < w - 1;
      // An invalid centre counts as zero; missing neighbours copy the centre.
      e  = wok[1][1] ? wv[1][1] : 0;
      a  = (top && lft && wok[0][0]) ? wv[0][0] : e;
      b  = (top && wok[0][1]) ? wv[0][1] : e;
      c  = (top && rgt && wok[0][2]) ? wv[0][2] : e;
      d  = (lft && wok[1][0]) ? wv[1][0] : e;
      f  = (rgt && wok[1][2]) ? wv[1][2] : e;
      g  = (bot && lft && wok[2][0]) ? wv[2][0] : e;
      hh = (bot && wok[2][1]) ? wv[2][1] : e;
      k  = (bot && rgt && wok[2][2]) ? wv[2][2] : e;
      beat.shade = horn_shade((c + 2 * f + k) - (a + 2 * d + g),
                              (g + 2 * hh + k) - (a + 2 * b + c));
      beat.col  = cc[OUT_COL_W-1:0];
      beat.row  = cr[ROWS_W-1:0];
      beat.last = (cr == h - 1) && (cc == w - 1);
      shade_expect_q.push_back(beat);
      got = 1;
    end
    for (int i = 0; i < 3; i++) begin
      win_v[i][0] = win_v[i][1]; win_ok[i][0] = win_ok[i][1];
      win_v[i][1] = win_v[i][2]; win_ok[i][1] = win_ok[i][2];
      win_v[i][2] = nv[i];       win_ok[i][2] = nok[i];
    end
    upper_v[ic] = nv[1];  upper_ok[ic] = nok[1];
    middle_v[ic] = nv[2]; middle_ok[ic] = nok[2];
    ic++;
    if (ic >= w) begin
      ic = 0; ir++;
    end
    col_cnt = ic;
    row_cnt = ir;
    if (got && beat.last) begin
      col_cnt = 0; row_cnt = 0;
    end
  endtask

  task automatic compare_beat();
    shade_beat_t want;
    shade_beat_t seen;
    seen.shade = m_axis_tdata[15:0];
    seen.col   = m_axis_tdata[25:16];
    seen.row   = m_axis_tdata[41:26];
    seen.last  = m_axis_tlast;
    if (shade_expect_q.size() == 0) begin
      $display("%0t: unexpected shade beat, actual shade %0d col %0d row %0d last %0d",
               $time, seen.shade, seen.col, seen.row, seen.last);
      err_count_o++;
      return;
    end
    want = shade_expect_q.pop_front();
    if (seen.shade !== want.shade) begin
      $display("%0t: shade mismatch, expected %0d actual %0d", $time, want.shade, seen.shade);
      err_count_o++;
    end
    if (seen.col !== want.col) begin
      $display("%0t: out_col mismatch, expected %0d actual %0d", $time, want.col, seen.col);
      err_count_o++;
    end
    if (seen.row !== want.row) begin
      $display("%0t: out_row mismatch, expected %0d actual %0d", $time, want.row, seen.row);
      err_count_o++;
    end
    if (seen.last !== want.last) begin
      $display("%0t: frame_last mismatch, expected %0d actual %0d", $time, want.last, seen.last);
      err_count_o++;
    end
  endtask

  // Values are sampled at the edge before the block updates its outputs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_reg = 11'd1024;
      rows_reg = 16'd1;
      gain_reg = 65536;
      cos_zen = 23170;
      sin_zen = 23170;
      cos_dir = -23170;
      sin_dir = 23170;
      restart_frame();
      shade_expect_q.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_beat();
      if (cfg_we_i) begin
        case (hs_reg_e'(cfg_idx_i))
          REG_COLS: begin
            cols_reg = cfg_data_i[COLS_REG_W-1:0];
            restart_frame();
          end
          REG_ROWS: begin
            rows_reg = cfg_data_i[ROWS_W-1:0];
            restart_frame();
          end
          REG_GAIN:    gain_reg = cfg_data_i;
          REG_COS_ZEN: cos_zen = longint'($signed(cfg_data_i[TRIG_W-1:0]));
          REG_SIN_ZEN: sin_zen = longint'($signed(cfg_data_i[TRIG_W-1:0]));
          REG_COS_DIR: cos_dir = longint'($signed(cfg_data_i[TRIG_W-1:0]));
          REG_SIN_DIR: sin_dir = longint'($signed(cfg_data_i[TRIG_W-1:0]));
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        take_sample(longint'($signed(s_axis_tdata)), s_axis_tuser);
      pending_o <= shade_expect_q.size();
    end
  end

  initial err_count_o = 0;

endmodule

// ----- tb/tb_hillshade_3x3_stencil_core.sv -----
// Testbench top for the hillshade stencil core: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_hillshade_3x3_stencil_core;
  import hshade_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [23:0]            s_axis_tdata;   // elevation
  logic                   s_axis_tuser;   // sample_valid
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // shade, out_col, out_row
  logic                   m_axis_tlast;   // frame_last
  int                     err_count;
  int                     pending;

  int     burst_left;
  int     sent_items;
  longint walk_elev;
  int     stall_mode;
  int     stall_left;
  int     stall_tick;

  hillshade_3x3_stencil_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  hshade_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .err_count_o(err_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Receiver stalls: switch between always ready, random and periodic patterns.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
      stall_tick = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 400);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        2:       m_axis_tready <= (stall_tick % 5) != 0;
        default: m_axis_tready <= (stall_tick % 40) >= 25;
      endcase
    end
  end

  // One sample beat; the sender may pause between bursts of random length.
  task automatic send_sample(logic [23:0] elev, logic ok);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= elev;
    s_axis_tuser  <= ok;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    sent_items++;
  endtask

  // Let every pending shade drain, then give the back end time to go quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(hs_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic configure(int cols, int rows, int gain, int cz, int sz, int cd, int sd);
    settle();
    write_reg(REG_GAIN, gain);
    write_reg(REG_COS_ZEN, cz[15:0]);
    write_reg(REG_SIN_ZEN, sz[15:0]);
    write_reg(REG_COS_DIR, cd[15:0]);
    write_reg(REG_SIN_DIR, sd[15:0]);
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
    @(posedge clk_i);
  endtask

  function automatic int to_q15(real x);
    int v;
    v = $rtoi(x * 32767.0);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  // Sample generator: 0 any value, 1 smooth terrain, 2 extreme values.
  task automatic next_elev(int mode, output logic [23:0] elev);
    case (mode)
      0: elev = $urandom;
      1: begin
        walk_elev = walk_elev + $urandom_range(0, 400) - 200;
        if (walk_elev > 8388607 || walk_elev < -8388608) walk_elev = 0;
        elev = walk_elev[23:0];
      end
      default: begin
        case ($urandom_range(0, 4))
          0: elev = 24'h7FFFFF;
          1: elev = 24'h800000;
          2: elev = 24'h000000;
          3: elev = 24'hFFFFFF;
          default: elev = 24'h000001;
        endcase
      end
    endcase
  endtask

  // A run of samples; a full frame is followed by its cols+1 filler beats.
  task automatic send_frame(int cols, int count, bit flush, int mode, int valid_pct);
    logic [23:0] elev;
    for (int i = 0; i < count; i++) begin
      next_elev(mode, elev);
      send_sample(elev, $urandom_range(1, 100) <= valid_pct);
    end
    if (flush)
      for (int i = 0; i <= cols; i++) send_sample($urandom, 1'b0);
  endtask

  // Random phase: fresh geometry and light, then one or two frames, the last of which may be cut off.
  task automatic random_phase();
    int  cols, rows, gain, mode, pct, frames, count;
    real zen, az;
    cols = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    rows = $urandom_range(1, 6);
    case ($urandom_range(0, 5))
      0:       gain = 0;
      1:       gain = 24'hFFFFFF;
      2:       gain = $urandom_range(0, 24'hFFFFFF);
      default: gain = $urandom_range(256, 262144);
    endcase
    zen = $urandom_range(0, 90) * 3.14159265 / 180.0;
    az  = $urandom_range(0, 359) * 3.14159265 / 180.0;
    if ($urandom_range(0, 4) == 0)
      configure(cols, rows, gain, $urandom_range(0, 65535) - 32768,
                $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                $urandom_range(0, 65535) - 32768);
    else
      configure(cols, rows, gain, to_q15($cos(zen)), to_q15($sin(zen)),
                to_q15($cos(az)), to_q15($sin(az)));
    mode = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : 1;
    case ($urandom_range(0, 2))
      0:       pct = 100;
      1:       pct = 90;
      default: pct = 50;
    endcase
    frames = $urandom_range(1, 2);
    for (int fr = 0; fr < frames; fr++) begin
      if ($urandom_range(0, 9) == 0) begin
        count = $urandom_range(1, cols * rows);
        send_frame(cols, count, 1'b0, mode, pct);
        fr = frames;
      end else begin
        count = cols * rows;
        send_frame(cols, count, 1'b1, mode, pct);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_COLS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    burst_left     = 0;
    sent_items     = 0;
    walk_elev      = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 3x3 frame of extreme and invalid samples at the largest gain.
    configure(3, 3, 24'hFFFFFF, 23170, 23170, -23170, 23170);
    send_sample(24'h7FFFFF, 1'b1);
    send_sample(24'h800000, 1'b1);
    send_sample(24'h000000, 1'b0);
    send_sample(24'hFFFFFF, 1'b1);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b1);
    send_sample(24'h000001, 1'b1);
    send_sample(24'h7FFFFF, 1'b1);
    send_sample(24'h800000, 1'b1);
    send_frame(3, 0, 1'b1, 0, 100);

    // Zero geometry acts as a single cell; all light registers at their largest value.
    configure(0, 0, 65536, 32767, 32767, 32767, 32767);
    send_frame(1, 1, 1'b1, 2, 100);

    // Zero gain with the most negative light values.
    configure(4, 2, 0, -32768, -32768, -32768, -32768);
    send_frame(4, 8, 1'b1, 2, 70);

    // Tallest frame setting, cut off after a few rows.
    configure(3, 16'hFFFF, 4096, 16384, 28377, 0, 32767);
    send_frame(3, 12, 1'b0, 1, 100);

    // Widest row: a register value above the line size acts as the full line.
    // One sample and the flush are enough to see where the row wraps.
    configure(11'h7FF, 1, 2048, 23170, 23170, -23170, 23170);
    send_frame(1024, 1, 1'b1, 1, 95);

    while (sent_items < 1400) random_phase();

    settle();
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
